[src/eevdf_runqueue_scheduler_macros.svh]
// ----------------------------------------------------------------------------
// EEVDF run-queue scheduler assertion macros
// Concurrent assertion wrappers that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef EEVDF_RUNQUEUE_SCHEDULER_MACROS_SVH
`define EEVDF_RUNQUEUE_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define EEVRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");
// Next-cycle implication, disabled during reset.
`define EEVRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define EEVRQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EEVRQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/eevrq_pkg.sv]
// ----------------------------------------------------------------------------
// EEVDF run-queue scheduler package
// Shared widths, codes, state encodings and interface structs.
// ----------------------------------------------------------------------------
package eevrq_pkg;

  // Default sizing.
  localparam int DEF_MAX_ENTRIES = 32;
  localparam int DEF_WEIGHT_UNIT = 1024;

  // Field widths.
  localparam int KEY_W    = 32;
  localparam int GEN_W    = 32;
  localparam int WEIGHT_W = 20;
  localparam int SLICE_W  = 32;
  localparam int TIME_W   = 64;
  localparam int PROD_W   = SLICE_W + WEIGHT_W;

  localparam logic [TIME_W-1:0] VMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SLICE_W-1:0] DEF_SLICE = 32'd4000000;

  // Command codes.
  typedef enum logic [3:0] {
    CMD_ADD     = 4'd0,
    CMD_RESET   = 4'd1,
    CMD_WAKE    = 4'd2,
    CMD_BLOCK   = 4'd3,
    CMD_EXIT    = 4'd4,
    CMD_CHARGE  = 4'd5,
    CMD_RUN     = 4'd6,
    CMD_REQUEUE = 4'd7,
    CMD_PICK    = 4'd8
  } cmd_t;

  // Entry modes.
  typedef enum logic [2:0] {
    MODE_EMPTY    = 3'd0,
    MODE_RUNNABLE = 3'd1,
    MODE_RUNNING  = 3'd2,
    MODE_BLOCKED  = 3'd3,
    MODE_EXITED   = 3'd4
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_FULL     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_CHK,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_WR,
    S_FLOOR,
    S_PICK,
    S_NEXT,
    S_FIN
  } state_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[src/eevrq_div.sv]
// ----------------------------------------------------------------------------
// EEVDF scheduler serial divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eevrq_div
  import eevrq_pkg::*;
#(
  parameter int DVD_W = PROD_W,
  parameter int DVS_W = WEIGHT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic             ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_r, dq_r[DVD_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      dq_nxt  = {dq_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; datapath registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = dq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[src/eevdf_runqueue_scheduler.sv]
// ----------------------------------------------------------------------------
// EEVDF run-queue scheduler
// Thread table with earliest eligible virtual deadline first selection.
// ----------------------------------------------------------------------------
// One command enters on the in_ channel (command in in_tuser, arguments in
// in_tdata) and produces exactly one result on the out_ channel. The block
// works on one command at a time and in_tready is low while it is busy.
// Every command first scans the used part of the table, one entry a cycle
// through the registered read port of the entry memories. Add, reset,
// wake, charge and requeue then run the shared multiplier and the serial
// divider (charge needs two passes) and all state-changing commands end
// with a second table scan that recomputes the minimum vruntime. A pick
// scans the table once, or three times when virtual time has to jump forward.
// The finished result sits in an output register; a new command is accepted
// while it waits, but the next result is held back until it is taken.
// Reset empties the table (used count zero) and sets default_slice to
// 4000000 ns; the entry memories themselves are not cleared.
// cfg_wr_en writes default_slice; write it only while the block is idle.
// ----------------------------------------------------------------------------
`include "eevdf_runqueue_scheduler_macros.svh"

module eevdf_runqueue_scheduler
  import eevrq_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int WEIGHT_UNIT = DEF_WEIGHT_UNIT
) (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: default_slice.
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  // Commands.
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: thread_key, generation_in, weight_in, slice_in, runtime_in, pad
  input  logic [151:0] in_tdata,
  // tuser: command
  input  logic [3:0]   in_tuser,
  // Results.
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: status, picked_valid, picked_thread, picked_generation, pad
  output logic [71:0]  out_tdata
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0]    MAX_CNT = CNT_W'(MAX_ENTRIES);
  localparam logic [WEIGHT_W-1:0] WU_W    = WEIGHT_W'(WEIGHT_UNIT);
  localparam logic [PROD_W-1:0]   WU_P    = PROD_W'(WEIGHT_UNIT);

  // Entry memories.
  logic [KEY_W-1:0]    mem_thread [MAX_ENTRIES];
  logic [GEN_W-1:0]    mem_gen    [MAX_ENTRIES];
  logic [WEIGHT_W-1:0] mem_weight [MAX_ENTRIES];
  logic [SLICE_W-1:0]  mem_slice  [MAX_ENTRIES];
  logic [TIME_W-1:0]   mem_vrt    [MAX_ENTRIES];
  logic [TIME_W-1:0]   mem_elig   [MAX_ENTRIES];
  logic [TIME_W-1:0]   mem_dl     [MAX_ENTRIES];
  logic [TIME_W-1:0]   mem_svc    [MAX_ENTRIES];
  mode_t               mem_mode   [MAX_ENTRIES];

  logic [KEY_W-1:0]    rd_thread_r;
  logic [GEN_W-1:0]    rd_gen_r;
  logic [WEIGHT_W-1:0] rd_weight_r;
  logic [SLICE_W-1:0]  rd_slice_r;
  logic [TIME_W-1:0]   rd_vrt_r, rd_elig_r, rd_dl_r, rd_svc_r;
  mode_t               rd_mode_r;

  // Sequencer and command registers.
  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [GEN_W-1:0]    gen_r, gen_nxt;
  logic [WEIGHT_W-1:0] win_r, win_nxt;
  logic [SLICE_W-1:0]  sin_r, sin_nxt;
  logic [31:0]         rt_r, rt_nxt;
  logic [SLICE_W-1:0]  dslice_r;

  // Scan control.
  logic [CNT_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    eval_idx_r, eval_idx_nxt;
  logic                scanning, issue, scan_done;
  logic [IDX_W-1:0]    rd_addr;

  // Global scheduler state.
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    runnable_r, runnable_nxt;
  logic [TIME_W-1:0]   floor_r, floor_nxt;
  logic [TIME_W-1:0]   qt_r, qt_nxt;

  // Working entry values.
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    k_r, k_nxt;
  logic [WEIGHT_W-1:0] wgt_w_r, wgt_w_nxt;
  logic [SLICE_W-1:0]  slc_w_r, slc_w_nxt;
  logic [TIME_W-1:0]   v_r, v_nxt;
  logic [TIME_W-1:0]   elig_w_r, elig_w_nxt;
  logic [TIME_W-1:0]   dl_w_r, dl_w_nxt;
  logic [TIME_W-1:0]   svc_r, svc_nxt;
  mode_t               mode_w_r, mode_w_nxt;
  logic                chg_ph_r, chg_ph_nxt;
  status_t             stat_r, stat_nxt;

  // Shared multiply and divide.
  logic [31:0]         mul_a_r, mul_a_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic                div_start;
  logic [PROD_W-1:0]   quot;
  div_stat_t           dstat;

  // Scan accumulators.
  logic                min_found_r, min_found_nxt;
  logic [TIME_W-1:0]   min_v_r, min_v_nxt;
  logic [CNT_W-1:0]    run_cnt_r, run_cnt_nxt;
  logic                best_found_r, best_found_nxt;
  logic [TIME_W-1:0]   best_dl_r, best_dl_nxt;
  logic [KEY_W-1:0]    best_thr_r, best_thr_nxt;
  logic [GEN_W-1:0]    best_gen_r, best_gen_nxt;
  logic                seen_r, seen_nxt;
  logic [TIME_W-1:0]   next_r, next_nxt;
  logic                pass_r, pass_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [71:0]         out_data_r, out_data_nxt;

  // Deadline and charge arithmetic on the divider result.
  logic [TIME_W-1:0]   e_val, s_val, dsum, csum;
  logic                wr_en;

  assign e_val = (v_r > floor_r) ? v_r : floor_r;
  assign s_val = (quot == '0) ? TIME_W'(1) : TIME_W'(quot);
  assign dsum  = e_val + s_val;
  assign csum  = v_r + TIME_W'(quot);

  eevrq_div #(
    .DVD_W (PROD_W),
    .DVS_W (WEIGHT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (wgt_w_r),
    .quotient (quot),
    .stat     (dstat)
  );

  // Scan address issue: one entry a cycle below the used count.
  assign scanning  = (state_r == S_LOOK) || (state_r == S_FLOOR) ||
                     (state_r == S_PICK) || (state_r == S_NEXT);
  assign issue     = scanning && (scan_cnt_r < used_r);
  assign scan_done = scanning && !issue && !pend_r;
  assign rd_addr   = issue ? scan_cnt_r[IDX_W-1:0] : k_r;
  assign div_start = (state_r == S_DIVGO);
  assign wr_en     = (state_r == S_WR);
  assign in_tready = (state_r == S_IDLE);

  // Entry memory read and write ports.
  always_ff @(posedge clk) begin
    rd_thread_r <= mem_thread[rd_addr];
    rd_gen_r    <= mem_gen[rd_addr];
    rd_weight_r <= mem_weight[rd_addr];
    rd_slice_r  <= mem_slice[rd_addr];
    rd_vrt_r    <= mem_vrt[rd_addr];
    rd_elig_r   <= mem_elig[rd_addr];
    rd_dl_r     <= mem_dl[rd_addr];
    rd_svc_r    <= mem_svc[rd_addr];
    rd_mode_r   <= mem_mode[rd_addr];
    if (wr_en) begin
      if ((cmd_r == CMD_ADD) || (cmd_r == CMD_RESET)) begin
        mem_thread[k_r] <= key_r;
        mem_gen[k_r]    <= gen_r;
      end
      mem_weight[k_r] <= wgt_w_r;
      mem_slice[k_r]  <= slc_w_r;
      mem_vrt[k_r]    <= v_r;
      mem_elig[k_r]   <= elig_w_r;
      mem_dl[k_r]     <= dl_w_r;
      mem_svc[k_r]    <= svc_r;
      mem_mode[k_r]   <= mode_w_r;
    end
  end

  // Shared multiplier: operand times the unit weight.
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(mul_a_r) * WU_P;
    end
  end

  // Default slice register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dslice_r <= DEF_SLICE;
    end else if (cfg_wr_en) begin
      dslice_r <= cfg_wr_data;
    end
  end

  // Sequencer next state and datapath.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    gen_nxt        = gen_r;
    win_nxt        = win_r;
    sin_nxt        = sin_r;
    rt_nxt         = rt_r;
    scan_cnt_nxt   = scan_cnt_r;
    pend_nxt       = 1'b0;
    eval_idx_nxt   = eval_idx_r;
    used_nxt       = used_r;
    runnable_nxt   = runnable_r;
    floor_nxt      = floor_r;
    qt_nxt         = qt_r;
    found_nxt      = found_r;
    k_nxt          = k_r;
    wgt_w_nxt      = wgt_w_r;
    slc_w_nxt      = slc_w_r;
    v_nxt          = v_r;
    elig_w_nxt     = elig_w_r;
    dl_w_nxt       = dl_w_r;
    svc_nxt        = svc_r;
    mode_w_nxt     = mode_w_r;
    chg_ph_nxt     = chg_ph_r;
    stat_nxt       = stat_r;
    mul_a_nxt      = mul_a_r;
    min_found_nxt  = min_found_r;
    min_v_nxt      = min_v_r;
    run_cnt_nxt    = run_cnt_r;
    best_found_nxt = best_found_r;
    best_dl_nxt    = best_dl_r;
    best_thr_nxt   = best_thr_r;
    best_gen_nxt   = best_gen_r;
    seen_nxt       = seen_r;
    next_nxt       = next_r;
    pass_nxt       = pass_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Common scan stepping.
    if (issue) begin
      scan_cnt_nxt = scan_cnt_r + 1'b1;
      pend_nxt     = 1'b1;
      eval_idx_nxt = scan_cnt_r[IDX_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = cmd_t'(in_tuser);
          key_nxt      = in_tdata[31:0];
          gen_nxt      = in_tdata[63:32];
          win_nxt      = in_tdata[83:64];
          sin_nxt      = in_tdata[115:84];
          rt_nxt       = in_tdata[147:116];
          scan_cnt_nxt = '0;
          found_nxt    = 1'b0;
          state_nxt    = S_LOOK;
        end
      end

      // Find the first non-empty entry holding the key.
      S_LOOK: begin
        if (pend_r && !found_r && (rd_thread_r == key_r) && (rd_mode_r != MODE_EMPTY)) begin
          found_nxt = 1'b1;
          k_nxt     = eval_idx_r;
        end
        if (scan_done) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        stat_nxt = ST_REJECT;
        case (cmd_r)
          CMD_ADD, CMD_RESET: begin
            if ((key_r == '0) || (found_r && (cmd_r == CMD_ADD))) begin
              state_nxt = S_FIN;
            end else if (!found_r && (used_r >= MAX_CNT)) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_FIN;
            end else begin
              if (!found_r) begin
                k_nxt    = used_r[IDX_W-1:0];
                used_nxt = used_r + 1'b1;
              end
              wgt_w_nxt  = (win_r == '0) ? WU_W : win_r;
              slc_w_nxt  = (sin_r == '0) ? dslice_r : sin_r;
              mul_a_nxt  = (sin_r == '0) ? dslice_r : sin_r;
              v_nxt      = floor_r;
              svc_nxt    = '0;
              mode_w_nxt = MODE_RUNNABLE;
              chg_ph_nxt = 1'b0;
              state_nxt  = S_MUL;
            end
          end
          CMD_WAKE, CMD_BLOCK, CMD_EXIT, CMD_CHARGE, CMD_RUN, CMD_REQUEUE: begin
            state_nxt = (found_r && (key_r != '0)) ? S_CHK : S_FIN;
          end
          CMD_PICK: begin
            scan_cnt_nxt   = '0;
            best_found_nxt = 1'b0;
            pass_nxt       = 1'b0;
            state_nxt      = S_PICK;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      // Entry k is in the read registers.
      S_CHK: begin
        wgt_w_nxt  = rd_weight_r;
        slc_w_nxt  = rd_slice_r;
        v_nxt      = rd_vrt_r;
        elig_w_nxt = rd_elig_r;
        dl_w_nxt   = rd_dl_r;
        svc_nxt    = rd_svc_r;
        mode_w_nxt = rd_mode_r;
        chg_ph_nxt = 1'b0;
        stat_nxt   = ST_REJECT;
        state_nxt  = S_FIN;
        case (cmd_r)
          CMD_WAKE: begin
            if (rd_mode_r == MODE_RUNNABLE) begin
              stat_nxt = ST_OK;
            end else if (rd_mode_r != MODE_EXITED) begin
              mode_w_nxt = MODE_RUNNABLE;
              v_nxt      = (rd_vrt_r < floor_r) ? floor_r : rd_vrt_r;
              mul_a_nxt  = rd_slice_r;
              state_nxt  = S_MUL;
            end
          end
          CMD_BLOCK: begin
            if (rd_mode_r != MODE_EXITED) begin
              mode_w_nxt = MODE_BLOCKED;
              state_nxt  = S_WR;
            end
          end
          CMD_EXIT: begin
            mode_w_nxt = MODE_EXITED;
            state_nxt  = S_WR;
          end
          CMD_CHARGE: begin
            if ((rd_mode_r == MODE_RUNNABLE) || (rd_mode_r == MODE_RUNNING)) begin
              mul_a_nxt  = rt_r;
              chg_ph_nxt = 1'b1;
              state_nxt  = S_MUL;
            end
          end
          CMD_RUN: begin
            if (rd_mode_r == MODE_RUNNABLE) begin
              mode_w_nxt = MODE_RUNNING;
              state_nxt  = S_WR;
            end
          end
          CMD_REQUEUE: begin
            if (rd_mode_r == MODE_RUNNING) begin
              mode_w_nxt = MODE_RUNNABLE;
              mul_a_nxt  = rd_slice_r;
              state_nxt  = S_MUL;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_MUL: begin
        state_nxt = S_DIVGO;
      end

      S_DIVGO: begin
        state_nxt = S_DIV;
      end

      // Divider result: either a charge delta or a weighted slice.
      S_DIV: begin
        if (dstat.done) begin
          if (chg_ph_r) begin
            chg_ph_nxt = 1'b0;
            if (csum[TIME_W-1]) begin
              stat_nxt  = ST_OVERFLOW;
              state_nxt = S_FIN;
            end else begin
              v_nxt     = csum;
              svc_nxt   = svc_r + TIME_W'(rt_r);
              mul_a_nxt = slc_w_r;
              state_nxt = S_MUL;
            end
          end else begin
            elig_w_nxt = e_val;
            dl_w_nxt   = dsum[TIME_W-1] ? VMAX : dsum;
            state_nxt  = S_WR;
          end
        end
      end

      S_WR: begin
        stat_nxt      = ST_OK;
        scan_cnt_nxt  = '0;
        min_found_nxt = 1'b0;
        run_cnt_nxt   = '0;
        state_nxt     = S_FLOOR;
      end

      // Minimum vruntime over active entries and runnable count.
      S_FLOOR: begin
        if (pend_r && ((rd_mode_r == MODE_RUNNABLE) || (rd_mode_r == MODE_RUNNING))) begin
          if (!min_found_r || (rd_vrt_r < min_v_r)) begin
            min_v_nxt     = rd_vrt_r;
            min_found_nxt = 1'b1;
          end
          if (rd_mode_r == MODE_RUNNABLE) begin
            run_cnt_nxt = run_cnt_r + 1'b1;
          end
        end
        if (scan_done) begin
          runnable_nxt = run_cnt_r;
          if (min_found_r) begin
            floor_nxt = min_v_r;
            if (qt_r < min_v_r) begin
              qt_nxt = min_v_r;
            end
          end
          state_nxt = S_FIN;
        end
      end

      // Best eligible runnable entry.
      S_PICK: begin
        if (pend_r && (rd_mode_r == MODE_RUNNABLE) && (rd_elig_r <= qt_r)) begin
          if (!best_found_r || (rd_dl_r < best_dl_r) ||
              ((rd_dl_r == best_dl_r) && (rd_thread_r < best_thr_r))) begin
            best_found_nxt = 1'b1;
            best_dl_nxt    = rd_dl_r;
            best_thr_nxt   = rd_thread_r;
            best_gen_nxt   = rd_gen_r;
          end
        end
        if (scan_done) begin
          if (best_found_r) begin
            stat_nxt  = ST_OK;
            state_nxt = S_FIN;
          end else if (!pass_r) begin
            scan_cnt_nxt = '0;
            seen_nxt     = 1'b0;
            state_nxt    = S_NEXT;
          end else begin
            stat_nxt  = ST_REJECT;
            state_nxt = S_FIN;
          end
        end
      end

      // Earliest future eligible time.
      S_NEXT: begin
        if (pend_r && (rd_mode_r == MODE_RUNNABLE) && (rd_elig_r > qt_r)) begin
          if (!seen_r || (rd_elig_r < next_r)) begin
            next_nxt = rd_elig_r;
            seen_nxt = 1'b1;
          end
        end
        if (scan_done) begin
          if (seen_r) begin
            qt_nxt       = next_r;
            pass_nxt     = 1'b1;
            scan_cnt_nxt = '0;
            state_nxt    = S_PICK;
          end else begin
            stat_nxt  = ST_REJECT;
            state_nxt = S_FIN;
          end
        end
      end

      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if ((cmd_r == CMD_PICK) && (stat_r == ST_OK)) begin
            out_data_nxt = {5'b0, best_gen_r, best_thr_r, 1'b1, stat_r};
          end else begin
            out_data_nxt = {5'b0, 32'b0, 32'b0, 1'b0, stat_r};
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      runnable_r  <= '0;
      floor_r     <= '0;
      qt_r        <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      scan_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      runnable_r  <= runnable_nxt;
      floor_r     <= floor_nxt;
      qt_r        <= qt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    gen_r        <= gen_nxt;
    win_r        <= win_nxt;
    sin_r        <= sin_nxt;
    rt_r         <= rt_nxt;
    eval_idx_r   <= eval_idx_nxt;
    found_r      <= found_nxt;
    k_r          <= k_nxt;
    wgt_w_r      <= wgt_w_nxt;
    slc_w_r      <= slc_w_nxt;
    v_r          <= v_nxt;
    elig_w_r     <= elig_w_nxt;
    dl_w_r       <= dl_w_nxt;
    svc_r        <= svc_nxt;
    mode_w_r     <= mode_w_nxt;
    chg_ph_r     <= chg_ph_nxt;
    stat_r       <= stat_nxt;
    mul_a_r      <= mul_a_nxt;
    min_found_r  <= min_found_nxt;
    min_v_r      <= min_v_nxt;
    run_cnt_r    <= run_cnt_nxt;
    best_found_r <= best_found_nxt;
    best_dl_r    <= best_dl_nxt;
    best_thr_r   <= best_thr_nxt;
    best_gen_r   <= best_gen_nxt;
    seen_r       <= seen_nxt;
    next_r       <= next_nxt;
    pass_r       <= pass_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks on the scheduler's own bookkeeping.
  `EEVRQ_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_r <= MAX_CNT)
  `EEVRQ_ASSERT_IMP(a_runnable_bound, clk, rst_n, 1'b1, runnable_r <= used_r)
  `EEVRQ_ASSERT_IMP(a_floor_le_qt, clk, rst_n, 1'b1, floor_r <= qt_r)
  `EEVRQ_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule
